### rtl/gdf_pkg.sv
// Shared types and constants for the gossip duplicate filter.
// Used by every module of the block; depends on nothing.
package gdf_pkg;

  localparam int SEEN_DEPTH_DEF = 64;

  localparam logic [31:0] MAX_AGE_RST   = 32'd300;
  localparam logic [7:0]  HOP_LIMIT_RST = 8'd10;
  localparam logic [6:0]  SEEN_CAP_RST  = 7'd64;
  localparam logic [31:0] SEEN_TTL_RST  = 32'd600;

  localparam int IN_DATA_W  = 392;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    FUNC_RECV  = 2'd0,
    FUNC_BCAST = 2'd1,
    FUNC_PURGE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    REG_MAX_AGE   = 4'h0,
    REG_HOP_LIMIT = 4'h4,
    REG_SEEN_CAP  = 4'h8,
    REG_SEEN_TTL  = 4'hC
  } reg_addr_t;

  typedef enum logic [2:0] {
    V_FORWARD   = 3'd0,
    V_DUPLICATE = 3'd1,
    V_TOO_OLD   = 3'd2,
    V_HOP_LIMIT = 3'd3,
    V_BCAST     = 3'd4,
    V_CLEANUP   = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_PURGE,
    B_DONE
  } bstate_t;

  typedef struct packed {
    logic [31:0] max_age;
    logic [7:0]  hop_limit;
    logic [6:0]  seen_cap;
    logic [31:0] seen_ttl;
  } cfg_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    func_t        func;
    logic [255:0] id;
    logic [63:0]  now;
    logic [7:0]   hop;
    logic         too_old;
    logic         hop_lim;
  } cmd_t;

  typedef struct packed {
    logic [255:0] id;
    logic [63:0]  stamp;
  } entry_t;

endpackage

### rtl/gossip_duplicate_filter_unit.sv
// Top level of the gossip duplicate filter: configuration registers and
// the front, queue and back parts. Depends on gdf_pkg, gdf_front, gdf_queue, gdf_back.
//
//  Channel    Dir   Handshake                Payload
//  s_axis     in    s_axis_tvalid/tready     tdata: ids, timestamp, hop, now; tuser: func
//  m_axis     out   m_axis_tvalid/tready     tdata: verdict, forward_hop, removed_count
//  APB        in    psel/penable/pready      4 registers at byte offsets 0, 4, 8, 12
//
// A broadcast or an unused code passes the front register, the queue and the
// back-end load before its result shows. A receive or a cleanup also scans the
// stored entries first, reading one memory entry a cycle; a receive stops after
// the matching entry. The front register and the queue hold up to three further
// transactions while the back end works.
// Reset empties the seen list at once; memory contents need no clearing.
// A stalled output holds the back end; the front keeps accepting until its queue fills.
module gossip_duplicate_filter_unit #(
  parameter int SEEN_DEPTH = gdf_pkg::SEEN_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [63:0] msg_id_w0, [127:64] msg_id_w1, [191:128] msg_id_w2, [255:192] msg_id_w3,
  // [319:256] msg_timestamp, [327:320] hop_count_in, [391:328] current time
  input  logic [gdf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [2:0] verdict, [10:3] forward_hop, [17:11] removed_count, [23:18] zero
  output logic [gdf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import gdf_pkg::*;

  cfg_t       cfg;
  logic       f_valid, f_ready, q_valid, q_ready;
  cmd_t       f_cmd, q_cmd;
  logic [2:0] verdict;
  logic [7:0] forward_hop;
  logic [6:0] removed_count;
  reg_addr_t  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_addr_t'({paddr[3:2], 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_age   <= MAX_AGE_RST;
      cfg.hop_limit <= HOP_LIMIT_RST;
      cfg.seen_cap  <= SEEN_CAP_RST;
      cfg.seen_ttl  <= SEEN_TTL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_MAX_AGE:   cfg.max_age   <= pwdata;
        REG_HOP_LIMIT: cfg.hop_limit <= pwdata[7:0];
        REG_SEEN_CAP:  cfg.seen_cap  <= pwdata[6:0];
        REG_SEEN_TTL:  cfg.seen_ttl  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_AGE:   prdata = cfg.max_age;
      REG_HOP_LIMIT: prdata = {24'd0, cfg.hop_limit};
      REG_SEEN_CAP:  prdata = {25'd0, cfg.seen_cap};
      REG_SEEN_TTL:  prdata = cfg.seen_ttl;
      default:       prdata = 32'd0;
    endcase
  end

  gdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_func   (s_axis_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  gdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  gdf_back #(
    .SEEN_DEPTH (SEEN_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .verdict       (verdict),
    .forward_hop   (forward_hop),
    .removed_count (removed_count)
  );

  assign m_axis_tdata = {6'd0, removed_count, forward_hop, verdict};

endmodule

### rtl/gdf_front.sv
// Front end: accepts input items and classifies them (age and hop checks).
// Depends on gdf_pkg.
module gdf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  gdf_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gdf_pkg::IN_DATA_W-1:0] in_data,
  input  logic [1:0]                    in_func,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output gdf_pkg::cmd_t                 cmd
);
  import gdf_pkg::*;

  logic [63:0] ts;
  logic [63:0] age;
  cmd_t        cmd_next;
  logic        full;

  assign ts  = in_data[319:256];
  assign age = in_data[391:328] - ts;

  always_comb begin
    cmd_next.func    = func_t'(in_func);
    cmd_next.id      = in_data[255:0];
    cmd_next.now     = in_data[391:328];
    cmd_next.hop     = in_data[327:320];
    cmd_next.too_old = age > {32'd0, cfg.max_age};
    cmd_next.hop_lim = in_data[327:320] >= cfg.hop_limit;
  end

  // Single register stage; it refills in the cycle it empties.
  assign full      = cmd_valid;
  assign in_ready  = !full || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

### rtl/gdf_queue.sv
// Two-entry queue of classified commands between front and back.
// Depends on gdf_pkg.
module gdf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  gdf_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output gdf_pkg::cmd_t pop_cmd
);
  import gdf_pkg::*;

  cmd_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_cmd    = slot[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= push_cmd;
    end
  end

endmodule

### rtl/gdf_back.sv
// Back end: seen-list memory kept as a ring, duplicate scan, record and purge.
// Depends on gdf_pkg.
module gdf_back #(
  parameter int SEEN_DEPTH = gdf_pkg::SEEN_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  gdf_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  gdf_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    verdict,
  output logic [7:0]    forward_hop,
  output logic [6:0]    removed_count
);
  import gdf_pkg::*;

  localparam int PW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int CW = $clog2(SEEN_DEPTH + 1);

  function automatic logic [PW-1:0] wrap(input logic [CW:0] s);
    logic [CW:0] d;
    d = s - (CW+1)'(SEEN_DEPTH);
    if (s >= (CW+1)'(SEEN_DEPTH)) begin
      return d[PW-1:0];
    end
    return s[PW-1:0];
  endfunction

  entry_t        mem [SEEN_DEPTH];
  entry_t        rdata;
  bstate_t       state, state_next;
  cmd_t          cur;
  logic [CW-1:0] count, count_next;
  logic [PW-1:0] head, head_next;
  logic [CW-1:0] iss, iss_next;
  logic          pend, pend_next;
  logic          found, found_next;
  logic [CW-1:0] wr, wr_next;
  logic [6:0]    rem, rem_next;
  logic [CW-1:0] eff_cap;
  logic          rd_en, we;
  logic [PW-1:0] rd_addr, wr_addr;
  entry_t        wdata;
  logic          load, fire, record, expired;
  verdict_t      v_next;
  logic [63:0]   age;

  always_comb begin
    if (cfg.seen_cap == 7'd0) begin
      eff_cap = CW'(1);
    end else if (32'(cfg.seen_cap) > 32'(SEEN_DEPTH)) begin
      eff_cap = CW'(SEEN_DEPTH);
    end else begin
      eff_cap = CW'(cfg.seen_cap);
    end
  end

  assign age     = cur.now - rdata.stamp;
  assign expired = age > {32'd0, cfg.seen_ttl};
  assign fire    = (state == B_DONE) && (!out_valid || out_ready);
  assign load    = (state == B_IDLE) && cmd_valid;
  assign record  = (cur.func == FUNC_BCAST) ||
                   (cur.func == FUNC_RECV && !found && !cur.too_old && !cur.hop_lim);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.func)
            FUNC_RECV:  state_next = B_SCAN;
            FUNC_PURGE: state_next = B_PURGE;
            default:    state_next = B_DONE;
          endcase
        end
      end
      B_SCAN: begin
        if (!pend && (found || iss == count)) begin
          state_next = B_DONE;
        end
      end
      B_PURGE: begin
        if (!pend && iss == count) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (fire) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready  = load;
    count_next = count;
    head_next  = head;
    iss_next   = iss;
    pend_next  = 1'b0;
    found_next = found;
    wr_next    = wr;
    rem_next   = rem;
    rd_en      = 1'b0;
    rd_addr    = wrap((CW+1)'(head) + (CW+1)'(iss));
    we         = 1'b0;
    wr_addr    = wrap((CW+1)'(head) + (CW+1)'(count));
    wdata      = rdata;
    v_next     = V_CLEANUP;
    unique case (state)
      B_IDLE: begin
        iss_next   = '0;
        found_next = 1'b0;
        wr_next    = '0;
        rem_next   = 7'd0;
      end
      B_SCAN: begin
        rd_en     = (iss != count) && !found;
        pend_next = rd_en;
        if (rd_en) begin
          iss_next = iss + CW'(1);
        end
        if (pend && rdata.id == cur.id) begin
          found_next = 1'b1;
        end
      end
      B_PURGE: begin
        rd_en     = iss != count;
        pend_next = rd_en;
        if (rd_en) begin
          iss_next = iss + CW'(1);
        end
        // Survivors slide down; the write slot never passes the read slot.
        if (pend && !expired) begin
          we      = 1'b1;
          wr_addr = wrap((CW+1)'(head) + (CW+1)'(wr));
          wr_next = wr + CW'(1);
        end
        if (!pend && iss == count) begin
          count_next = wr;
          rem_next   = 7'(count - wr);
        end
      end
      B_DONE: begin
        wdata.id    = cur.id;
        wdata.stamp = cur.now;
        if (fire && record) begin
          we = 1'b1;
          if (count >= eff_cap) begin
            head_next = wrap((CW+1)'(head) + (CW+1)'(1));
          end else begin
            count_next = count + CW'(1);
          end
        end
      end
      default: ;
    endcase
    priority if (cur.func == FUNC_RECV && found) begin
      v_next = V_DUPLICATE;
    end else if (cur.func == FUNC_RECV && cur.too_old) begin
      v_next = V_TOO_OLD;
    end else if (cur.func == FUNC_RECV && cur.hop_lim) begin
      v_next = V_HOP_LIMIT;
    end else if (cur.func == FUNC_RECV) begin
      v_next = V_FORWARD;
    end else if (cur.func == FUNC_BCAST) begin
      v_next = V_BCAST;
    end else begin
      v_next = V_CLEANUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      count     <= '0;
      head      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      pend  <= pend_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= cmd;
    end
    iss   <= iss_next;
    found <= found_next;
    wr    <= wr_next;
    rem   <= rem_next;
    if (fire) begin
      verdict       <= v_next;
      forward_hop   <= (v_next == V_FORWARD) ? cur.hop + 8'd1 : 8'd0;
      removed_count <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule
